// ===== sv/hpid_pkg.sv =====
// ----------------------------------------------------------------------------
// hpid_pkg
// Types, constants and the angle wrap function shared by the heading
// controller modules.
// ----------------------------------------------------------------------------
package hpid_pkg;

   // Fixed-point formats: angles Q.6 (1/64 degree), gains and alpha Q.12.
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int GAIN_FRAC_BITS  = 12;
   localparam int SUM_SHIFT       = ANGLE_FRAC_BITS + 2 * GAIN_FRAC_BITS;

   // Port and register widths.
   localparam int OFFSET_W  = 16;
   localparam int YAW_W     = 15;
   localparam int TURN_W    = 11;
   localparam int GAIN_W    = 16;
   localparam int ALPHA_W   = 13;
   localparam int ILIM_W    = 16;
   localparam int OLIM_W    = 10;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   // Internal widths.
   localparam int ANGLE_W   = 15;  // wrapped error, +/-180 degrees
   localparam int RAW_W     = 18;  // unwrapped angle sums
   localparam int ESUM_W    = 18;  // integral of the error
   localparam int FILT_W    = 28;  // filtered difference, Q.(A+G)
   localparam int MUL_A_W   = 17;  // gains, zero extended
   localparam int MUL_B_W   = 28;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 48;

   // Three folds cover the whole range of the unwrapped error.
   localparam int WRAP_STEPS = 3;

   localparam logic signed [RAW_W-1:0] HALF_TURN = RAW_W'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [RAW_W-1:0] FULL_TURN = RAW_W'(360 << ANGLE_FRAC_BITS);
   localparam logic [ALPHA_W-1:0]      GAIN_ONE  = ALPHA_W'(1 << GAIN_FRAC_BITS);
   localparam logic signed [ACC_W-1:0] TRUNC_BIAS =
      ACC_W'((64'sd1 <<< SUM_SHIFT) - 64'sd1);
   localparam logic signed [FILT_W-1:0] FILT_MAX =
      FILT_W'(64'sd180 <<< (ANGLE_FRAC_BITS + GAIN_FRAC_BITS));

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERROR,
      ST_ACCUM,
      ST_MUL_DECAY,
      ST_MUL_ALPHA,
      ST_MUL_PROP,
      ST_MUL_INTEG,
      ST_MUL_DERIV,
      ST_COMBINE,
      ST_OUTPUT
   } state_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_SHR,
      ACC_ADD,
      ACC_LOAD,
      ACC_SHL_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      MUL_DECAY,
      MUL_ALPHA,
      MUL_PROP,
      MUL_INTEG,
      MUL_DERIV
   } mul_sel_type;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN,
      CSR_INTEG_GAIN,
      CSR_DERIV_GAIN,
      CSR_SMOOTH_FACTOR,
      CSR_INTEG_LIMIT,
      CSR_OUTPUT_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic       prod_en;
      acc_op_type acc_op;
   } mac_ctrl_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  integ_gain;
      logic [GAIN_W-1:0]  deriv_gain;
      logic [ALPHA_W-1:0] smooth_factor;
      logic [ILIM_W-1:0]  integ_limit;
      logic [OLIM_W-1:0]  output_limit;
   } cfg_type;

   // Folds an angle into [-180, +180] degrees; both ends are kept.
   function automatic logic signed [RAW_W-1:0] wrap_angle(
      input logic signed [RAW_W-1:0] a);
      logic signed [RAW_W-1:0] v;
      v = a;
      for (int i = 0; i < WRAP_STEPS; i++) begin
         if (v > HALF_TURN) begin
            v = v - FULL_TURN;
         end else if (v < -HALF_TURN) begin
            v = v + FULL_TURN;
         end
      end
      return v;
   endfunction

endpackage

// ===== sv/hpid_csr.sv =====
// ----------------------------------------------------------------------------
// hpid_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module hpid_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [hpid_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [hpid_pkg::DATA_W-1:0] csr_pwdata,
   output logic [hpid_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready,
   output hpid_pkg::cfg_type           cfg
);
   import hpid_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index  = csr_paddr[ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            CSR_PROP_GAIN:     cfg_in.prop_gain     = csr_pwdata[GAIN_W-1:0];
            CSR_INTEG_GAIN:    cfg_in.integ_gain    = csr_pwdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:    cfg_in.deriv_gain    = csr_pwdata[GAIN_W-1:0];
            CSR_SMOOTH_FACTOR: cfg_in.smooth_factor = csr_pwdata[ALPHA_W-1:0];
            CSR_INTEG_LIMIT:   cfg_in.integ_limit   = csr_pwdata[ILIM_W-1:0];
            CSR_OUTPUT_LIMIT:  cfg_in.output_limit  = csr_pwdata[OLIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         CSR_PROP_GAIN:     csr_prdata = DATA_W'(cfg_ff.prop_gain);
         CSR_INTEG_GAIN:    csr_prdata = DATA_W'(cfg_ff.integ_gain);
         CSR_DERIV_GAIN:    csr_prdata = DATA_W'(cfg_ff.deriv_gain);
         CSR_SMOOTH_FACTOR: csr_prdata = DATA_W'(cfg_ff.smooth_factor);
         CSR_INTEG_LIMIT:   csr_prdata = DATA_W'(cfg_ff.integ_limit);
         CSR_OUTPUT_LIMIT:  csr_prdata = DATA_W'(cfg_ff.output_limit);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain     <= GAIN_W'(1024);
         cfg_ff.integ_gain    <= '0;
         cfg_ff.deriv_gain    <= GAIN_W'(819);
         cfg_ff.smooth_factor <= ALPHA_W'(614);
         cfg_ff.integ_limit   <= ILIM_W'(32000);
         cfg_ff.output_limit  <= OLIM_W'(50);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/hpid_mac.sv =====
// ----------------------------------------------------------------------------
// hpid_mac
// Shared multiplier with a registered product and a 48-bit accumulator.
// ----------------------------------------------------------------------------
module hpid_mac (
   input  logic                                clock,
   input  hpid_pkg::mac_ctrl_type              ctrl,
   input  logic signed [hpid_pkg::MUL_A_W-1:0] mul_a,
   input  logic signed [hpid_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [hpid_pkg::ACC_W-1:0]   acc
);
   import hpid_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   assign prod_ext = ACC_W'(prod_ff);
   assign acc      = acc_ff;

   always_comb begin
      prod_in = ctrl.prod_en ? mul_a * mul_b : prod_ff;
   end

   // The arithmetic shift right rounds toward minus infinity, as the
   // filter's decay term requires.
   always_comb begin
      unique case (ctrl.acc_op)
         ACC_HOLD:     acc_in = acc_ff;
         ACC_LOAD_SHR: acc_in = prod_ext >>> GAIN_FRAC_BITS;
         ACC_ADD:      acc_in = acc_ff + prod_ext;
         ACC_LOAD:     acc_in = prod_ext;
         ACC_SHL_ADD:  acc_in = (acc_ff <<< GAIN_FRAC_BITS) + prod_ext;
         default:      acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

// ===== sv/heading_pid_with_angle_wrap.sv =====
// ----------------------------------------------------------------------------
// heading_pid_with_angle_wrap
// Heading PID controller with wrapped error and low-pass filtered derivative.
// ----------------------------------------------------------------------------
// Each item is one control tick: a target offset and the current yaw, both in
// 1/64 degree. The first item after reset latches its yaw as the reference
// heading. The block returns one turn value per item. An item is taken in the
// idle state and a new one only once the sequence has come back to idle:
// six of its steps are passes through the single shared 17 x 28-bit
// multiplier and its accumulator (filter decay, filter input, proportional,
// integral, derivative and the final combine), the rest take the item in and
// form the wrapped error, the clamped integral and the saturated output. The
// next item is accepted while an earlier result still waits in the output
// register; the sequencer only holds in its last state if that register is
// still full.
// ----------------------------------------------------------------------------
module heading_pid_with_angle_wrap (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [hpid_pkg::OFFSET_W-1:0] req_target_offset,
   input  logic signed [hpid_pkg::YAW_W-1:0]    req_current_yaw,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [hpid_pkg::TURN_W-1:0]   rsp_turn_value,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [hpid_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [hpid_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [hpid_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                 csr_pready
);
   import hpid_pkg::*;

   cfg_type      cfg;
   mac_ctrl_type mac_ctrl;
   mul_sel_type  mul_sel;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [ACC_W-1:0]   acc;

   state_type state_ff, state_in;

   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic signed [YAW_W-1:0]    yaw_ff, yaw_in;
   logic signed [YAW_W-1:0]    start_heading_ff, start_heading_in;
   logic                       heading_latched_ff, heading_latched_in;
   logic signed [ESUM_W-1:0]   error_sum_ff, error_sum_in;
   logic signed [ANGLE_W-1:0]  prev_error_ff, prev_error_in;
   logic signed [ANGLE_W-1:0]  err_ff, err_in;
   logic signed [ANGLE_W-1:0]  diff_ff, diff_in;
   logic signed [FILT_W-1:0]   filt_ff, filt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [TURN_W-1:0]   turn_ff, turn_in;

   logic signed [YAW_W-1:0]   heading_ref;
   logic signed [RAW_W-1:0]   err_raw;
   logic signed [RAW_W-1:0]   diff_raw;
   logic signed [ESUM_W-1:0]  sum_raw;
   logic signed [ESUM_W-1:0]  ilim;
   logic [ALPHA_W-1:0]        alpha;
   logic [ALPHA_W-1:0]        decay;
   logic signed [ACC_W-1:0]   sat_pos;
   logic signed [ACC_W-1:0]   sat_neg;
   logic signed [ACC_W-1:0]   trunc_sum;
   logic signed [TURN_W-1:0]  olim;

   hpid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   hpid_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .acc   (acc)
   );

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_turn_value = turn_ff;

   // Error and difference, each folded back into a half turn either way.
   assign heading_ref = heading_latched_ff ? start_heading_ff : yaw_ff;
   assign err_raw     = RAW_W'(heading_ref) + RAW_W'(offset_ff) - RAW_W'(yaw_ff);
   assign diff_raw    = RAW_W'(err_ff) - RAW_W'(prev_error_ff);
   assign sum_raw     = error_sum_ff + ESUM_W'(err_ff);
   assign ilim        = signed'(ESUM_W'(cfg.integ_limit));

   assign alpha = (cfg.smooth_factor > GAIN_ONE) ? GAIN_ONE : cfg.smooth_factor;
   assign decay = GAIN_ONE - alpha;

   always_comb begin
      unique case (mul_sel)
         MUL_DECAY: begin
            mul_a = signed'(MUL_A_W'(decay));
            mul_b = MUL_B_W'(filt_ff);
         end
         MUL_ALPHA: begin
            mul_a = signed'(MUL_A_W'(alpha));
            mul_b = MUL_B_W'(diff_ff);
         end
         MUL_PROP: begin
            mul_a = signed'(MUL_A_W'(cfg.prop_gain));
            mul_b = MUL_B_W'(err_ff);
         end
         MUL_INTEG: begin
            mul_a = signed'(MUL_A_W'(cfg.integ_gain));
            mul_b = MUL_B_W'(error_sum_ff);
         end
         MUL_DERIV: begin
            mul_a = signed'(MUL_A_W'(cfg.deriv_gain));
            mul_b = MUL_B_W'(filt_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Output saturation and truncation toward zero.
   assign sat_pos   = signed'(ACC_W'(cfg.output_limit) << SUM_SHIFT);
   assign sat_neg   = -sat_pos;
   assign olim      = signed'(TURN_W'(cfg.output_limit));
   assign trunc_sum = (acc + ((acc < 0) ? TRUNC_BIAS : '0)) >>> SUM_SHIFT;

   always_comb begin
      state_in           = state_ff;
      offset_in          = offset_ff;
      yaw_in             = yaw_ff;
      start_heading_in   = start_heading_ff;
      heading_latched_in = heading_latched_ff;
      error_sum_in       = error_sum_ff;
      prev_error_in      = prev_error_ff;
      err_in             = err_ff;
      diff_in            = diff_ff;
      filt_in            = filt_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      turn_in            = turn_ff;
      mac_ctrl.prod_en   = 1'b0;
      mac_ctrl.acc_op    = ACC_HOLD;
      mul_sel            = MUL_DECAY;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               offset_in = req_target_offset;
               yaw_in    = req_current_yaw;
               state_in  = ST_ERROR;
            end
         end
         ST_ERROR: begin
            err_in             = ANGLE_W'(wrap_angle(err_raw));
            start_heading_in   = heading_ref;
            heading_latched_in = 1'b1;
            state_in           = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (sum_raw > ilim) begin
               error_sum_in = ilim;
            end else if (sum_raw < -ilim) begin
               error_sum_in = -ilim;
            end else begin
               error_sum_in = sum_raw;
            end
            diff_in       = ANGLE_W'(wrap_angle(diff_raw));
            prev_error_in = err_ff;
            state_in      = ST_MUL_DECAY;
         end
         ST_MUL_DECAY: begin
            mul_sel          = MUL_DECAY;
            mac_ctrl.prod_en = 1'b1;
            state_in         = ST_MUL_ALPHA;
         end
         ST_MUL_ALPHA: begin
            mul_sel          = MUL_ALPHA;
            mac_ctrl.prod_en = 1'b1;
            mac_ctrl.acc_op  = ACC_LOAD_SHR;
            state_in         = ST_MUL_PROP;
         end
         ST_MUL_PROP: begin
            mul_sel          = MUL_PROP;
            mac_ctrl.prod_en = 1'b1;
            mac_ctrl.acc_op  = ACC_ADD;
            state_in         = ST_MUL_INTEG;
         end
         ST_MUL_INTEG: begin
            // The accumulator now holds the new filtered difference.
            filt_in          = FILT_W'(acc);
            mul_sel          = MUL_INTEG;
            mac_ctrl.prod_en = 1'b1;
            mac_ctrl.acc_op  = ACC_LOAD;
            state_in         = ST_MUL_DERIV;
         end
         ST_MUL_DERIV: begin
            mul_sel          = MUL_DERIV;
            mac_ctrl.prod_en = 1'b1;
            mac_ctrl.acc_op  = ACC_ADD;
            state_in         = ST_COMBINE;
         end
         ST_COMBINE: begin
            mac_ctrl.acc_op = ACC_SHL_ADD;
            state_in        = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (acc > sat_pos) begin
                  turn_in = olim;
               end else if (acc < sat_neg) begin
                  turn_in = -olim;
               end else begin
                  turn_in = trunc_sum[TURN_W-1:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         rsp_valid_ff       <= 1'b0;
         start_heading_ff   <= '0;
         heading_latched_ff <= 1'b0;
         error_sum_ff       <= '0;
         prev_error_ff      <= '0;
         filt_ff            <= '0;
      end else begin
         state_ff           <= state_in;
         rsp_valid_ff       <= rsp_valid_in;
         start_heading_ff   <= start_heading_in;
         heading_latched_ff <= heading_latched_in;
         error_sum_ff       <= error_sum_in;
         prev_error_ff      <= prev_error_in;
         filt_ff            <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      yaw_ff    <= yaw_in;
      err_ff    <= err_in;
      diff_ff   <= diff_in;
      turn_ff   <= turn_in;
   end

   // An accepted item always starts with the error step.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_ERROR)
      else $error("accepted item did not start the error step");

   // Once latched, the reference heading stays latched until reset.
   assert property (@(posedge clock) disable iff (reset)
      heading_latched_ff |=> heading_latched_ff)
      else $error("reference heading lost its latch");

   // The filtered difference stays within a half turn in Q.(A+G).
   assert property (@(posedge clock) disable iff (reset)
      filt_ff <= FILT_MAX && filt_ff >= -FILT_MAX)
      else $error("filtered difference out of range");

   // A new result only appears at the end of the sequence.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUTPUT))
      else $error("result raised outside the output step");

   // A waiting result never exceeds the output bound.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (turn_ff <= olim && turn_ff >= -olim))
      else $error("turn value beyond output limit");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heading PID controller with angle wrap.
// ----------------------------------------------------------------------------
// Control ticks go in through the request channel and a bit-exact predictor
// of the controller works out each turn value as the tick is accepted. The
// results are checked in order as they leave. Both sides idle at random,
// the receiver holds off once for a long stretch, and the registers are
// rewritten and read back between phases, extreme settings included.
// ----------------------------------------------------------------------------
module testbench;

   localparam int OFFSET_W  = hpid_pkg::OFFSET_W;
   localparam int YAW_W     = hpid_pkg::YAW_W;
   localparam int TURN_W    = hpid_pkg::TURN_W;
   localparam int ADDR_W    = hpid_pkg::ADDR_W;
   localparam int DATA_W    = hpid_pkg::DATA_W;
   localparam int GAIN_FRAC = hpid_pkg::GAIN_FRAC_BITS;
   localparam int SUM_FRAC  = hpid_pkg::SUM_SHIFT;
   localparam int CSR_COUNT = int'(hpid_pkg::CSR_OUTPUT_LIMIT) + 1;

   localparam longint HALF_TURN_Q = longint'(180) << hpid_pkg::ANGLE_FRAC_BITS;
   localparam longint FULL_TURN_Q = longint'(360) << hpid_pkg::ANGLE_FRAC_BITS;
   localparam longint UNITY_Q     = longint'(1) << GAIN_FRAC;

   localparam int OFFSET_MAX      = 23040;
   localparam int YAW_MAX         = 11520;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 20;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [OFFSET_W-1:0] req_target_offset = '0;
   logic signed [YAW_W-1:0]    req_current_yaw = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [TURN_W-1:0]   rsp_turn_value;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]          csr_paddr = '0;
   logic [DATA_W-1:0]          csr_pwdata = '0;
   logic [DATA_W-1:0]          csr_prdata;
   logic                       csr_pready;
   logic                       moving;

   // Predicted controller state and register copy.
   hpid_pkg::cfg_type          csr_model;
   longint                     ref_heading = 0;
   bit                         heading_held = 1'b0;
   longint                     err_integral = 0;
   longint                     last_err = 0;
   longint                     diff_lowpass = 0;
   logic signed [TURN_W-1:0]   turn_expected[$];

   int unsigned                failures = 0;
   bit                         gaps_on = 1'b1;
   bit                         stalls_on = 1'b1;
   bit                         hold_off_pending = 1'b0;
   int                         yaw_track = 0;
   int                         offset_hold = 0;

   heading_pid_with_angle_wrap u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_offset (req_target_offset),
      .req_current_yaw   (req_current_yaw),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_turn_value    (rsp_turn_value),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   assign moving = (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
                   (csr_psel && csr_penable);

   function automatic longint fold_angle(input longint a);
      longint v;
      v = a;
      while (v > HALF_TURN_Q) v = v - FULL_TURN_Q;
      while (v < -HALF_TURN_Q) v = v + FULL_TURN_Q;
      return v;
   endfunction

   function automatic logic signed [TURN_W-1:0] predict_turn(input longint offset,
                                                             input longint yaw);
      longint err, step, alpha, lim, olim, bound, acc, turn, kp, ki, kd;
      kp    = csr_model.prop_gain;
      ki    = csr_model.integ_gain;
      kd    = csr_model.deriv_gain;
      alpha = csr_model.smooth_factor;
      lim   = csr_model.integ_limit;
      olim  = csr_model.output_limit;
      // The first tick after reset sets the reference heading.
      if (!heading_held) begin
         ref_heading  = yaw;
         heading_held = 1'b1;
      end
      err = fold_angle(ref_heading + offset - yaw);
      err_integral = err_integral + err;
      if (err_integral > lim) err_integral = lim;
      if (err_integral < -lim) err_integral = -lim;
      step = fold_angle(err - last_err);
      if (alpha > UNITY_Q) alpha = UNITY_Q;
      diff_lowpass = alpha * step + (((UNITY_Q - alpha) * diff_lowpass) >>> GAIN_FRAC);
      acc = (kp * err + ki * err_integral) * UNITY_Q + kd * diff_lowpass;
      last_err = err;
      bound = olim <<< SUM_FRAC;
      if (acc > bound) begin
         turn = olim;
      end else if (acc < -bound) begin
         turn = -olim;
      end else if (acc < 0) begin
         turn = -((-acc) >>> SUM_FRAC);
      end else begin
         turn = acc >>> SUM_FRAC;
      end
      return TURN_W'(turn);
   endfunction

   // Every accepted tick produces exactly one turn value.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         turn_expected.push_back(predict_turn(req_target_offset, req_current_yaw));
      end
   end

   always @(posedge clock) begin : check_turn
      logic signed [TURN_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (turn_expected.size() == 0) begin
            $display("%0t: turn_value expected none, actual %0d", $time, rsp_turn_value);
            failures++;
         end else begin
            want = turn_expected.pop_front();
            if (rsp_turn_value !== want) begin
               $display("%0t: turn_value expected %0d, actual %0d",
                        $time, want, rsp_turn_value);
               failures++;
            end
         end
      end
   end

   // Result receiver: random stall bursts, plus one long hold-off on request.
   initial begin : receiver
      @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (moving) quiet = 0;
         else quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   task automatic write_csr(input int idx, input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(4 * idx);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         hpid_pkg::CSR_PROP_GAIN:     csr_model.prop_gain     = value[15:0];
         hpid_pkg::CSR_INTEG_GAIN:    csr_model.integ_gain    = value[15:0];
         hpid_pkg::CSR_DERIV_GAIN:    csr_model.deriv_gain    = value[15:0];
         hpid_pkg::CSR_SMOOTH_FACTOR: csr_model.smooth_factor = value[12:0];
         hpid_pkg::CSR_INTEG_LIMIT:   csr_model.integ_limit   = value[15:0];
         hpid_pkg::CSR_OUTPUT_LIMIT:  csr_model.output_limit  = value[9:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_csr(input int idx);
      logic [DATA_W-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_W'(4 * idx);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         hpid_pkg::CSR_PROP_GAIN:     want = DATA_W'(csr_model.prop_gain);
         hpid_pkg::CSR_INTEG_GAIN:    want = DATA_W'(csr_model.integ_gain);
         hpid_pkg::CSR_DERIV_GAIN:    want = DATA_W'(csr_model.deriv_gain);
         hpid_pkg::CSR_SMOOTH_FACTOR: want = DATA_W'(csr_model.smooth_factor);
         hpid_pkg::CSR_INTEG_LIMIT:   want = DATA_W'(csr_model.integ_limit);
         default:                     want = DATA_W'(csr_model.output_limit);
      endcase
      if (csr_prdata !== want) begin
         $display("%0t: register %0d expected %0h, actual %0h",
                  $time, idx, want, csr_prdata);
         failures++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_all_csrs;
      for (int i = 0; i < CSR_COUNT; i++) read_csr(i);
   endtask

   task automatic send_tick(input int offset, input int yaw);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_target_offset <= OFFSET_W'(offset);
      req_current_yaw   <= YAW_W'(yaw);
      do @(posedge clock); while (!req_ready);
   endtask

   // Leaves the block idle: no item offered and every result collected.
   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (turn_expected.size() != 0);
   endtask

   function automatic int extreme_of(input int limit);
      case ($urandom_range(0, 2))
         0:       return -limit;
         1:       return 0;
         default: return limit;
      endcase
   endfunction

   // Mostly a yaw that drifts under a held target, with some noise and extremes.
   task automatic send_random_tick;
      int pick, offset, yaw;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         offset = int'($urandom_range(0, 2 * OFFSET_MAX)) - OFFSET_MAX;
         yaw    = int'($urandom_range(0, 2 * YAW_MAX)) - YAW_MAX;
      end else if (pick == 1) begin
         offset = extreme_of(OFFSET_MAX);
         yaw    = extreme_of(YAW_MAX);
      end else begin
         if ($urandom_range(0, 24) == 0) begin
            offset_hold = int'($urandom_range(0, 2 * OFFSET_MAX)) - OFFSET_MAX;
         end
         yaw_track = yaw_track + int'($urandom_range(0, 600)) - 300;
         if (yaw_track > YAW_MAX) yaw_track = yaw_track - 2 * YAW_MAX;
         else if (yaw_track < -YAW_MAX) yaw_track = yaw_track + 2 * YAW_MAX;
         offset = offset_hold;
         yaw    = yaw_track;
      end
      send_tick(offset, yaw);
   endtask

   task automatic test_reset_state;
      check_all_csrs();
   endtask

   // Error exactly at both half turns, folds once and twice, and jumps
   // across the half turn in the difference.
   task automatic test_directed_ticks;
      int offsets [16] = '{0, OFFSET_MAX / 2, OFFSET_MAX / 2, -OFFSET_MAX / 2,
                           OFFSET_MAX, -OFFSET_MAX, OFFSET_MAX, 0,
                           0, 0, -1, 0, -OFFSET_MAX, OFFSET_MAX, 1, -1};
      int yaws    [16] = '{-YAW_MAX, -YAW_MAX, -YAW_MAX, -YAW_MAX,
                           -YAW_MAX, YAW_MAX, YAW_MAX, YAW_MAX,
                           0, -1, 0, YAW_MAX - 1, -YAW_MAX, 0, -YAW_MAX, YAW_MAX};
      for (int i = 0; i < 16; i++) send_tick(offsets[i], yaws[i]);
      drain_results();
   endtask

   task automatic test_special_configs;
      // A weight above one must act as no filtering.
      write_csr(hpid_pkg::CSR_SMOOTH_FACTOR, 32'h0000_1FFF);
      send_tick(OFFSET_MAX / 2, -YAW_MAX);
      send_tick(-OFFSET_MAX / 2, -YAW_MAX);
      drain_results();
      // With a zero integral limit even the largest gain adds nothing.
      write_csr(hpid_pkg::CSR_INTEG_GAIN, 32'h0000_FFFF);
      write_csr(hpid_pkg::CSR_INTEG_LIMIT, 32'h0);
      send_tick(OFFSET_MAX / 2, -YAW_MAX);
      send_tick(OFFSET_MAX / 2, -YAW_MAX);
      drain_results();
      // Full-scale gain pushes the output into both bounds.
      write_csr(hpid_pkg::CSR_PROP_GAIN, 32'h0000_FFFF);
      write_csr(hpid_pkg::CSR_OUTPUT_LIMIT, 32'h0000_03FF);
      send_tick(OFFSET_MAX / 2, -YAW_MAX);
      send_tick(-OFFSET_MAX / 2, -YAW_MAX);
      drain_results();
      write_csr(hpid_pkg::CSR_OUTPUT_LIMIT, 32'h0);
      send_tick(OFFSET_MAX / 2, -YAW_MAX);
      send_tick(-OFFSET_MAX / 2, -YAW_MAX);
      drain_results();
      // Upper bits of a written value are dropped.
      write_csr(hpid_pkg::CSR_OUTPUT_LIMIT, 32'hFFFF_FC05);
      send_tick(OFFSET_MAX / 2, -YAW_MAX);
      send_tick(-OFFSET_MAX / 2, YAW_MAX);
      drain_results();
      // Writes beyond the register map must leave every register alone.
      write_csr(CSR_COUNT, 32'hFFFF_FFFF);
      write_csr(CSR_COUNT + 1, 32'hFFFF_FFFF);
      check_all_csrs();
      send_tick(0, 0);
      send_tick(OFFSET_MAX, YAW_MAX);
      drain_results();
   endtask

   task automatic test_random_ticks;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               write_csr(hpid_pkg::CSR_PROP_GAIN, $urandom_range(0, 8192));
               write_csr(hpid_pkg::CSR_INTEG_GAIN, $urandom_range(0, 64));
               write_csr(hpid_pkg::CSR_DERIV_GAIN, $urandom_range(0, 8192));
               write_csr(hpid_pkg::CSR_SMOOTH_FACTOR, $urandom_range(0, 4096));
               write_csr(hpid_pkg::CSR_INTEG_LIMIT, $urandom_range(0, 65535));
               write_csr(hpid_pkg::CSR_OUTPUT_LIMIT, 32'h0000_03FF);
            end
            1: begin
               write_csr(hpid_pkg::CSR_PROP_GAIN, 32'h0000_FFFF);
               write_csr(hpid_pkg::CSR_INTEG_GAIN, 32'h0000_FFFF);
               write_csr(hpid_pkg::CSR_DERIV_GAIN, 32'h0000_FFFF);
               write_csr(hpid_pkg::CSR_SMOOTH_FACTOR, 32'h0000_1FFF);
               write_csr(hpid_pkg::CSR_INTEG_LIMIT, 32'h0000_FFFF);
               write_csr(hpid_pkg::CSR_OUTPUT_LIMIT, 32'h0000_03FF);
            end
            2: begin
               for (int i = 0; i < CSR_COUNT; i++) write_csr(i, 32'h0);
            end
            3: begin
               for (int i = 0; i < CSR_COUNT; i++) write_csr(i, $urandom);
            end
            4: begin
               write_csr(hpid_pkg::CSR_PROP_GAIN, 32'd1024);
               write_csr(hpid_pkg::CSR_INTEG_GAIN, $urandom_range(0, 255));
               write_csr(hpid_pkg::CSR_DERIV_GAIN, 32'd819);
               write_csr(hpid_pkg::CSR_SMOOTH_FACTOR, 32'd614);
               write_csr(hpid_pkg::CSR_INTEG_LIMIT, $urandom_range(0, 2000));
               write_csr(hpid_pkg::CSR_OUTPUT_LIMIT, 32'd50);
            end
            default: begin
               write_csr(hpid_pkg::CSR_PROP_GAIN, $urandom_range(0, 65535));
               write_csr(hpid_pkg::CSR_INTEG_GAIN, $urandom_range(0, 1024));
               write_csr(hpid_pkg::CSR_DERIV_GAIN, $urandom_range(0, 65535));
               write_csr(hpid_pkg::CSR_SMOOTH_FACTOR, $urandom_range(4096, 8191));
               write_csr(hpid_pkg::CSR_INTEG_LIMIT, $urandom_range(0, 65535));
               write_csr(hpid_pkg::CSR_OUTPUT_LIMIT, $urandom_range(0, 1023));
            end
         endcase
         check_all_csrs();
         repeat (105) send_random_tick();
         drain_results();
      end
   endtask

   // The receiver stops long enough for the block to fill and refuse ticks.
   task automatic test_output_backpressure;
      gaps_on = 1'b0;
      hold_off_pending = 1'b1;
      repeat (40) send_random_tick();
      drain_results();
   endtask

   task automatic test_steady_stream;
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (150) send_random_tick();
      drain_results();
   endtask

   initial begin : main
      csr_model.prop_gain     = 16'd1024;
      csr_model.integ_gain    = 16'd0;
      csr_model.deriv_gain    = 16'd819;
      csr_model.smooth_factor = 13'd614;
      csr_model.integ_limit   = 16'd32000;
      csr_model.output_limit  = 10'd50;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_ticks();
      test_special_configs();
      test_random_ticks();
      test_output_backpressure();
      test_steady_stream();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && turn_expected.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
